// ===== design/lll_pkg.sv =====
`default_nettype none
package lll_pkg;

	localparam int LAMPS   = 8;
	localparam int IDX_W   = 3;
	localparam int CNT_W   = 4;
	localparam int SEC_W   = 32;
	localparam int HRS_W   = 16;
	localparam int BYTE_W  = 8;
	localparam int CFG_W   = 64;
	localparam int CFGI_W  = 2;
	localparam int DIV_W   = 22;
	localparam int STEP_W  = $clog2(SEC_W);

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_PRESET = 2'd2;

	localparam logic [CFGI_W-1:0] CFG_NUM_LAMPS   = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_LIFE_LIMITS = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_MULTIPLIER  = 2'd2;

	localparam logic [DIV_W-1:0] SECS_PER_HOUR = 22'd3600;
	localparam logic [SEC_W-1:0] PCT_NEAR      = 32'd97;
	localparam logic [SEC_W-1:0] PCT_END       = 32'd100;

	typedef struct packed {
		logic [1:0]       operation;
		logic [IDX_W-1:0] lamp_index;
		logic [SEC_W-1:0] preset_seconds;
		logic [LAMPS-1:0] error_mask;
		logic             output_on;
	} in_word_t;

	typedef struct packed {
		logic [HRS_W-1:0] hours_used;
		logic             alarm_near_end;
		logic             alarm_end;
		logic             lamp_fault;
		logic [CNT_W-1:0] fault_count;
	} out_word_t;

endpackage
`default_nettype wire

// ===== design/lll_div.sv =====
`default_nettype none
module lll_div (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire [lll_pkg::SEC_W-1:0] dividend,
	input  wire [lll_pkg::DIV_W-1:0] divisor,
	output logic                     done,
	output logic [lll_pkg::SEC_W-1:0] quotient
);
	import lll_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SEC_W-1:0]  quo_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    diff;
	logic              fits;

	// one quotient bit per cycle: dividend shifts out the top, quotient fills the bottom
	always_comb begin
		trial = {rem_q, quo_q[SEC_W-1]};
		fits  = trial >= {1'b0, divisor};
		diff  = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SEC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[SEC_W-2:0], fits};
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ===== design/lamp_life_hour_meter_core.sv =====
// Lamp life hour meter.
// Input channel in_valid/in_stall/in_word carries one command word: a
// one-second tick, a read of one lamp's stored hours, or a preset of one
// lamp's second counter. Every command gives exactly one word on
// out_valid/out_stall/out_word: the hours (read only, else 0) and the
// latched alarm and fault status after the command.
// Read, preset and an undriven tick go from IDLE to DONE and then into the
// output register. A driven tick walks the lamps in use one after another:
// a faulty lamp is only counted in SCAN, a healthy one goes through SCAN,
// LOAD and DIV (two 32-step bit-serial dividers working side by side, for
// hours and percent of life). One command is worked on at a time; in_stall
// stays high until the output register has taken the word. A finished word
// waits in the output register while out_stall is high, and the next
// command is already accepted and worked on meanwhile. Reset clears all
// second and hour counters and alarms, sets the lamp count and life limits
// to 0 and the limit multiplier to 1. The user must write configuration
// words on cfg_we/cfg_index/cfg_data only while no command is in flight;
// the block itself does not enforce this.
`default_nettype none
module lamp_life_hour_meter_core (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  lll_pkg::in_word_t          in_word,
	output logic                       out_valid,
	input  wire                        out_stall,
	output lll_pkg::out_word_t         out_word,
	input  wire                        cfg_we,
	input  wire [lll_pkg::CFGI_W-1:0]  cfg_index,
	input  wire [lll_pkg::CFG_W-1:0]   cfg_data
);
	import lll_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  num_lamps_q;
	logic [CFG_W-1:0]  limits_q;
	logic [BYTE_W-1:0] mult_q;

	logic [SEC_W-1:0]  seconds_q [LAMPS];
	logic [HRS_W-1:0]  hours_q [LAMPS];

	in_word_t          cmd_q;
	logic [CNT_W-1:0]  lamp_q;
	logic [SEC_W-1:0]  sec_q;
	logic [HRS_W-1:0]  lim_q;
	logic [HRS_W-1:0]  read_hrs_q;
	logic              near_q;
	logic              end_q;
	logic [CNT_W-1:0]  faults_q;

	logic              alarm_near_q;
	logic              alarm_end_q;
	logic              fault_flag_q;
	logic [CNT_W-1:0]  fault_total_q;
	logic              out_valid_q;
	out_word_t         out_word_q;

	logic              accept;
	logic              emit;
	logic [CNT_W-1:0]  used;
	logic [IDX_W-1:0]  lamp_idx;
	logic [BYTE_W-1:0] lim_byte;
	logic [HRS_W-1:0]  lim_prod;
	logic [DIV_W-1:0]  lim36;
	logic              div_start;
	logic              div_done;
	logic              pct_done;
	logic [SEC_W-1:0]  q_hours;
	logic [SEC_W-1:0]  q_pct;
	logic [HRS_W-1:0]  hrs_new;
	logic              in_range;
	logic              nxt_near;
	logic              nxt_end;
	logic              nxt_fault;
	logic [CNT_W-1:0]  nxt_total;

	assign in_stall  = state_q != ST_IDLE;
	assign accept    = in_valid && !in_stall;
	assign emit      = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign used      = (num_lamps_q > CNT_W'(LAMPS)) ? CNT_W'(LAMPS) : num_lamps_q;
	assign lamp_idx  = lamp_q[IDX_W-1:0];
	assign lim_byte  = limits_q[{lamp_idx, 3'b000} +: BYTE_W];
	assign lim_prod  = HRS_W'({8'b0, lim_byte} * {8'b0, mult_q});
	assign lim36     = DIV_W'({lim_q, 5'b0}) + DIV_W'({lim_q, 2'b0});
	assign div_start = state_q == ST_LOAD;
	assign in_range  = int'(in_word.lamp_index) < LAMPS;
	assign hrs_new   = (lim_q == '0) ? '0 :
	                   (q_hours > {16'b0, lim_q}) ? lim_q : q_hours[HRS_W-1:0];

	lll_div u_div_hours (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sec_q),
		.divisor  (SECS_PER_HOUR),
		.done     (div_done),
		.quotient (q_hours)
	);

	lll_div u_div_pct (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sec_q),
		.divisor  (lim36),
		.done     (pct_done),
		.quotient (q_pct)
	);

	// status after the command: a tick rewrites it, other commands keep it
	always_comb begin
		if (cmd_q.operation == OP_TICK) begin
			nxt_near  = near_q;
			nxt_end   = end_q;
			nxt_fault = faults_q != '0;
			nxt_total = faults_q;
		end else begin
			nxt_near  = alarm_near_q;
			nxt_end   = alarm_end_q;
			nxt_fault = fault_flag_q;
			nxt_total = fault_total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_lamps_q <= '0;
			limits_q    <= '0;
			mult_q      <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_LAMPS:   num_lamps_q <= cfg_data[CNT_W-1:0];
				CFG_LIFE_LIMITS: limits_q    <= cfg_data;
				CFG_MULTIPLIER:  mult_q      <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAMPS; i++) begin
				seconds_q[i] <= '0;
				hours_q[i]   <= '0;
			end
		end else begin
			if (accept && in_word.operation == OP_PRESET && in_range) begin
				seconds_q[in_word.lamp_index] <= in_word.preset_seconds;
			end
			if (state_q == ST_DIV && div_done) begin
				seconds_q[lamp_idx] <= sec_q;
				hours_q[lamp_idx]   <= hrs_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			lamp_q        <= '0;
			near_q        <= 1'b0;
			end_q         <= 1'b0;
			faults_q      <= '0;
			alarm_near_q  <= 1'b0;
			alarm_end_q   <= 1'b0;
			fault_flag_q  <= 1'b0;
			fault_total_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// hold the word until the receiver takes it
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						lamp_q   <= '0;
						near_q   <= 1'b0;
						end_q    <= 1'b0;
						faults_q <= '0;
						if (in_word.operation == OP_TICK && in_word.output_on) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (lamp_q >= used) begin
						state_q <= ST_DONE;
					end else if (cmd_q.error_mask[lamp_idx]) begin
						faults_q <= faults_q + 1'b1;
						lamp_q   <= lamp_q + 1'b1;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						if (lim_q != '0 && q_pct >= PCT_NEAR) near_q <= 1'b1;
						if (lim_q != '0 && q_pct >= PCT_END)  end_q  <= 1'b1;
						lamp_q  <= lamp_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_DONE: begin
					if (emit) begin
						alarm_near_q  <= nxt_near;
						alarm_end_q   <= nxt_end;
						fault_flag_q  <= nxt_fault;
						fault_total_q <= nxt_total;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= in_word;
			read_hrs_q <= (in_word.operation == OP_READ && in_range) ?
			              hours_q[in_word.lamp_index] : '0;
		end
		// fetch the counter and limit of the lamp about to be divided
		if (state_q == ST_SCAN) begin
			sec_q <= seconds_q[lamp_idx] + 1'b1;
			lim_q <= lim_prod;
		end
		if (emit) begin
			out_word_q.hours_used     <= read_hrs_q;
			out_word_q.alarm_near_end <= nxt_near;
			out_word_q.alarm_end      <= nxt_end;
			out_word_q.lamp_fault     <= nxt_fault;
			out_word_q.fault_count    <= nxt_total;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("command accepted but sequencer stayed idle");

	a_div_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV && pct_done))
		else $error("divider finished outside the divide step");

	a_end_implies_near: assert property (@(posedge clk) disable iff (!arst_n)
		alarm_end_q |-> alarm_near_q)
		else $error("end-of-life alarm without near-end alarm");

	a_fault_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(faults_q <= CNT_W'(LAMPS)) && (fault_flag_q == (fault_total_q != '0)))
		else $error("fault count out of range or flag mismatch");

endmodule
`default_nettype wire
